// ===== hw/rtl/ccl_pkg.sv =====
`default_nettype none

package ccl_pkg;

	localparam int unsigned BIN_W          = 54;
	localparam int unsigned NUM_DIGITS     = 17;
	localparam int unsigned BCD_W          = 4 * NUM_DIGITS;
	localparam int unsigned BITS_PER_STAGE = 6;
	localparam int unsigned DABBLE_STAGES  = BIN_W / BITS_PER_STAGE;
	localparam int unsigned COUNT_W        = 5;
	localparam int unsigned PART_W         = 6;
	localparam int unsigned SUM_W          = 8;
	localparam int unsigned LEAD_LO        = 12;
	localparam int unsigned LEAD_N         = 4;

	localparam logic [COUNT_W-1:0] LEN_VISA_SHORT = COUNT_W'(13);
	localparam logic [COUNT_W-1:0] LEN_AMEX       = COUNT_W'(15);
	localparam logic [COUNT_W-1:0] LEN_LONG       = COUNT_W'(16);

	localparam logic [3:0] DIGIT_AMEX_HI  = 4'd3;
	localparam logic [3:0] DIGIT_AMEX_LO0 = 4'd4;
	localparam logic [3:0] DIGIT_AMEX_LO1 = 4'd7;
	localparam logic [3:0] DIGIT_MC_HI    = 4'd5;
	localparam logic [3:0] DIGIT_MC_LO_MIN = 4'd1;
	localparam logic [3:0] DIGIT_MC_LO_MAX = 4'd5;
	localparam logic [3:0] DIGIT_VISA     = 4'd4;

	typedef enum logic [1:0] {
		CLASS_INVALID    = 2'd0,
		CLASS_AMEX       = 2'd1,
		CLASS_MASTERCARD = 2'd2,
		CLASS_VISA       = 2'd3
	} card_class_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin;
		logic [BCD_W-1:0] bcd;
	} dabble_t;

	typedef struct packed {
		logic [COUNT_W-1:0]          count;
		logic [PART_W-1:0]           sum_a;
		logic [PART_W-1:0]           sum_b;
		logic [PART_W-1:0]           sum_c;
		logic [LEAD_N-1:0][3:0]      lead;
	} luhn_t;

	function automatic logic [3:0] luhn_term(logic [3:0] d, logic dbl);
		logic [4:0] t;
		t = {d, 1'b0};
		if (!dbl) begin
			return d;
		end
		if (t > 5'd9) begin
			t = t - 5'd9;
		end
		return t[3:0];
	endfunction

	function automatic logic is_mult10(logic [SUM_W-1:0] s);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < 26; k++) begin
			if (s == SUM_W'(10 * k)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ccl_dabble_stage.sv =====
`default_nettype none

module ccl_dabble_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              valid_in,
	input  wire ccl_pkg::dabble_t  data_in,
	output logic                   valid_sk,
	output ccl_pkg::dabble_t       data_sk
);

	ccl_pkg::dabble_t nxt;

	always_comb begin
		nxt = data_in;
		for (int k = 0; k < ccl_pkg::BITS_PER_STAGE; k++) begin
			for (int j = 0; j < ccl_pkg::NUM_DIGITS; j++) begin
				if (nxt.bcd[4*j +: 4] >= 4'd5) begin
					nxt.bcd[4*j +: 4] = nxt.bcd[4*j +: 4] + 4'd3;
				end
			end
			nxt.bcd = {nxt.bcd[ccl_pkg::BCD_W-2:0], nxt.bin[ccl_pkg::BIN_W-1]};
			nxt.bin = {nxt.bin[ccl_pkg::BIN_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sk <= 1'b0;
		end else if (adv) begin
			valid_sk <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_sk <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ccl_luhn_sum.sv =====
`default_nettype none

module ccl_luhn_sum (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          valid_in,
	input  wire logic [ccl_pkg::BCD_W-1:0]     bcd,
	output logic                               valid_s10,
	output ccl_pkg::luhn_t                     luhn_s10
);

	ccl_pkg::luhn_t nxt;

	always_comb begin
		nxt = '0;
		for (int i = 0; i < ccl_pkg::NUM_DIGITS; i++) begin
			if (bcd[4*i +: 4] != 4'd0) begin
				nxt.count = ccl_pkg::COUNT_W'(i + 1);
			end
		end
		for (int i = 0; i < 6; i++) begin
			nxt.sum_a = nxt.sum_a + ccl_pkg::PART_W'(ccl_pkg::luhn_term(bcd[4*i +: 4], i[0]));
		end
		for (int i = 6; i < 12; i++) begin
			nxt.sum_b = nxt.sum_b + ccl_pkg::PART_W'(ccl_pkg::luhn_term(bcd[4*i +: 4], i[0]));
		end
		for (int i = 12; i < ccl_pkg::NUM_DIGITS; i++) begin
			nxt.sum_c = nxt.sum_c + ccl_pkg::PART_W'(ccl_pkg::luhn_term(bcd[4*i +: 4], i[0]));
		end
		for (int i = 0; i < ccl_pkg::LEAD_N; i++) begin
			nxt.lead[i] = bcd[4*(ccl_pkg::LEAD_LO + i) +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (adv) begin
			valid_s10 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			luhn_s10 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ccl_classify.sv =====
`default_nettype none

module ccl_classify (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           adv,
	input  wire logic                           valid_in,
	input  wire ccl_pkg::luhn_t                 luhn,
	output logic                                valid_s11,
	output ccl_pkg::card_class_t                class_s11,
	output logic                                ok_s11,
	output logic [ccl_pkg::COUNT_W-1:0]         count_s11
);

	logic [ccl_pkg::SUM_W-1:0]   sum;
	logic                        ok;
	logic [3:0]                  d12;
	logic [3:0]                  d13;
	logic [3:0]                  d14;
	logic [3:0]                  d15;
	ccl_pkg::card_class_t        cls;
	logic [ccl_pkg::COUNT_W-1:0] count_sat;

	always_comb begin
		sum = ccl_pkg::SUM_W'(luhn.sum_a) + ccl_pkg::SUM_W'(luhn.sum_b)
			+ ccl_pkg::SUM_W'(luhn.sum_c);
		ok  = ccl_pkg::is_mult10(sum);
		d12 = luhn.lead[12 - ccl_pkg::LEAD_LO];
		d13 = luhn.lead[13 - ccl_pkg::LEAD_LO];
		d14 = luhn.lead[14 - ccl_pkg::LEAD_LO];
		d15 = luhn.lead[15 - ccl_pkg::LEAD_LO];
		cls = ccl_pkg::CLASS_INVALID;
		if (ok) begin
			if (luhn.count == ccl_pkg::LEN_AMEX && d14 == ccl_pkg::DIGIT_AMEX_HI
					&& (d13 == ccl_pkg::DIGIT_AMEX_LO0 || d13 == ccl_pkg::DIGIT_AMEX_LO1)) begin
				cls = ccl_pkg::CLASS_AMEX;
			end else if (luhn.count == ccl_pkg::LEN_LONG && d15 == ccl_pkg::DIGIT_MC_HI
					&& d14 >= ccl_pkg::DIGIT_MC_LO_MIN && d14 <= ccl_pkg::DIGIT_MC_LO_MAX) begin
				cls = ccl_pkg::CLASS_MASTERCARD;
			end else if ((luhn.count == ccl_pkg::LEN_VISA_SHORT && d12 == ccl_pkg::DIGIT_VISA)
					|| (luhn.count == ccl_pkg::LEN_LONG && d15 == ccl_pkg::DIGIT_VISA)) begin
				cls = ccl_pkg::CLASS_VISA;
			end
		end
		count_sat = (luhn.count > ccl_pkg::LEN_LONG) ? ccl_pkg::LEN_LONG : luhn.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else if (adv) begin
			valid_s11 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			class_s11 <= cls;
			ok_s11    <= ok;
			count_s11 <= count_sat;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/card_number_luhn_classifier_top.sv =====
// Card number check: each item carries a binary card number, converted to decimal by a
// nine-stage double-dabble pipeline (six bits per stage), followed by one stage of digit
// count and partial Luhn sums and one output stage that finishes the mod-10 test and the
// class (0 invalid, 1 amex, 2 mastercard, 3 visa). One item is taken every cycle while
// card_stall is low; the pipeline moves as one, so card_stall is high exactly while a result
// waits under result_stall. digit_count saturates at 16 for seventeen-digit inputs.
`default_nettype none

module card_number_luhn_classifier_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         card_valid,
	output logic                              card_stall,
	input  wire logic [ccl_pkg::BIN_W-1:0]    card_number,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic [1:0]                        card_class,
	output logic                              luhn_ok,
	output logic [ccl_pkg::COUNT_W-1:0]       digit_count
);

	logic                 adv;
	logic                 dab_valid [ccl_pkg::DABBLE_STAGES+1];
	ccl_pkg::dabble_t     dab_data  [ccl_pkg::DABBLE_STAGES+1];
	logic                 valid_s10;
	ccl_pkg::luhn_t       luhn_s10;
	ccl_pkg::card_class_t class_s11;

	assign adv        = !(result_valid && result_stall);
	assign card_stall = !adv;

	assign dab_valid[0]    = card_valid;
	assign dab_data[0].bin = card_number;
	assign dab_data[0].bcd = '0;

	for (genvar g = 0; g < ccl_pkg::DABBLE_STAGES; g++) begin : g_dabble
		ccl_dabble_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.valid_in (dab_valid[g]),
			.data_in  (dab_data[g]),
			.valid_sk (dab_valid[g+1]),
			.data_sk  (dab_data[g+1])
		);
	end

	ccl_luhn_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (dab_valid[ccl_pkg::DABBLE_STAGES]),
		.bcd       (dab_data[ccl_pkg::DABBLE_STAGES].bcd),
		.valid_s10 (valid_s10),
		.luhn_s10  (luhn_s10)
	);

	ccl_classify u_class (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (valid_s10),
		.luhn      (luhn_s10),
		.valid_s11 (result_valid),
		.class_s11 (class_s11),
		.ok_s11    (luhn_ok),
		.count_s11 (digit_count)
	);

	assign card_class = class_s11;

endmodule

`default_nettype wire

// ===== hw/rtl/ccl_checker.sv =====
`default_nettype none

module ccl_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         card_stall,
	input wire logic                         result_valid,
	input wire logic                         result_stall,
	input wire logic [1:0]                   card_class,
	input wire logic                         luhn_ok,
	input wire logic [ccl_pkg::COUNT_W-1:0]  digit_count
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(card_class)
			&& $stable(luhn_ok) && $stable(digit_count))
		else $error("result changed while stalled");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		card_stall == (result_valid && result_stall))
		else $error("input stall does not follow output backpressure");

	a_class_luhn: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && card_class != ccl_pkg::CLASS_INVALID |-> luhn_ok)
		else $error("card class given without Luhn pass");

	a_class_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(card_class != ccl_pkg::CLASS_AMEX || digit_count == ccl_pkg::LEN_AMEX)
			&& (card_class != ccl_pkg::CLASS_MASTERCARD || digit_count == ccl_pkg::LEN_LONG)
			&& (card_class != ccl_pkg::CLASS_VISA || digit_count == ccl_pkg::LEN_LONG
				|| digit_count == ccl_pkg::LEN_VISA_SHORT))
		else $error("card class does not match digit count");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && digit_count == '0 |-> luhn_ok && card_class == ccl_pkg::CLASS_INVALID)
		else $error("zero input gave wrong result");

endmodule

bind card_number_luhn_classifier_top ccl_checker u_ccl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.card_stall   (card_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.card_class   (card_class),
	.luhn_ok      (luhn_ok),
	.digit_count  (digit_count)
);

`default_nettype wire
